// ----- rtl/ezq_pkg.sv -----
// Shared constants, types and the arctangent table for the Euler-to-quaternion pipe.
// Used by ezq_cordic and euler_zyx_to_quaternion; no dependencies.
package ezq_pkg;

   localparam int ANGLE_W         = 24;
   localparam int MAX_W           = 23;
   localparam int QUAT_W          = 16;
   localparam int STATUS_W        = 2;
   localparam int ANGLE_FRAC_BITS = 16;
   localparam int TRIG_STAGES     = 16;
   localparam int ATAN_ENTRIES    = 24;

   // CORDIC datapath widths
   localparam int CW     = 33;   // x, y, z
   localparam int TW     = 18;   // sine/cosine, Q15 with headroom
   localparam int PHASE_W = 32;

   localparam logic [MAX_W-1:0] MAX_ANGLE_RST = 23'd6588397;
   localparam logic [30:0]      INV_TWO_PI    = 31'd683565276;
   localparam logic [CW-1:0]    CORDIC_ONE    = 33'd652032875;
   localparam logic [33:0]      NORM_ONE      = 34'd1073741824;
   localparam logic [33:0]      NORM_TOL      = 34'd10737418;

   localparam logic [STATUS_W-1:0] ST_OK        = 2'd0;
   localparam logic [STATUS_W-1:0] ST_RANGE     = 2'd1;
   localparam logic [STATUS_W-1:0] ST_NORM_FAIL = 2'd2;

   localparam logic REG_MAX_ANGLE = 1'b0;

   typedef logic signed [TW-1:0] trig_type;

   // arctangent of 2^-i in units of 2^-32 turn
   function automatic logic signed [CW-1:0] atan_turn(input logic [4:0] idx);
      logic signed [CW-1:0] r;
      begin
         unique case (idx)
            5'd0:  r = 33'sd536870912;
            5'd1:  r = 33'sd316933406;
            5'd2:  r = 33'sd167458907;
            5'd3:  r = 33'sd85004756;
            5'd4:  r = 33'sd42667331;
            5'd5:  r = 33'sd21354465;
            5'd6:  r = 33'sd10679838;
            5'd7:  r = 33'sd5340245;
            5'd8:  r = 33'sd2670163;
            5'd9:  r = 33'sd1335087;
            5'd10: r = 33'sd667544;
            5'd11: r = 33'sd333772;
            5'd12: r = 33'sd166886;
            5'd13: r = 33'sd83443;
            5'd14: r = 33'sd41722;
            5'd15: r = 33'sd20861;
            5'd16: r = 33'sd10430;
            5'd17: r = 33'sd5215;
            5'd18: r = 33'sd2608;
            5'd19: r = 33'sd1304;
            5'd20: r = 33'sd652;
            5'd21: r = 33'sd326;
            5'd22: r = 33'sd163;
            5'd23: r = 33'sd81;
            default: r = '0;
         endcase
         return r;
      end
   endfunction

endpackage

// ----- rtl/ezq_cordic.sv -----
// One rotation-mode CORDIC lane, one stage per register, plus quadrant fold and Q15 rounding.
// Depends on ezq_pkg. The input register, the STAGES rotation registers and the output register all advance on adv.
module ezq_cordic #(
   parameter int STAGES = ezq_pkg::TRIG_STAGES
) (
   input  logic                              clock,
   input  logic                              adv,
   input  logic signed [ezq_pkg::CW-1:0]     z_in,
   input  logic        [1:0]                 quad_in,
   output ezq_pkg::trig_type                 cos_out,
   output ezq_pkg::trig_type                 sin_out
);

   localparam int CW = ezq_pkg::CW;

   logic signed [CW-1:0] x_ff [0:STAGES];
   logic signed [CW-1:0] y_ff [0:STAGES];
   logic signed [CW-1:0] z_ff [0:STAGES];
   logic        [1:0]    quad_ff [0:STAGES];
   ezq_pkg::trig_type    cos_ff, sin_ff;

   always_ff @(posedge clock) begin
      if (adv) begin
         x_ff[0]    <= ezq_pkg::CORDIC_ONE;
         y_ff[0]    <= '0;
         z_ff[0]    <= z_in;
         quad_ff[0] <= quad_in;
      end
   end

   for (genvar i = 0; i < STAGES; i++) begin : g_stage
      logic signed [CW-1:0] xs, ys, at;
      assign xs = x_ff[i] >>> i;
      assign ys = y_ff[i] >>> i;
      assign at = ezq_pkg::atan_turn(5'(i));
      always_ff @(posedge clock) begin
         if (adv) begin
            quad_ff[i+1] <= quad_ff[i];
            if (!z_ff[i][CW-1]) begin
               x_ff[i+1] <= x_ff[i] - ys;
               y_ff[i+1] <= y_ff[i] + xs;
               z_ff[i+1] <= z_ff[i] - at;
            end else begin
               x_ff[i+1] <= x_ff[i] + ys;
               y_ff[i+1] <= y_ff[i] - xs;
               z_ff[i+1] <= z_ff[i] + at;
            end
         end
      end
   end

   logic signed [CW-1:0] c_raw, s_raw;
   logic signed [CW:0]   c_sum, s_sum;

   always_comb begin
      unique case (quad_ff[STAGES])
         2'd0: begin c_raw = x_ff[STAGES];  s_raw = y_ff[STAGES];  end
         2'd1: begin c_raw = -y_ff[STAGES]; s_raw = x_ff[STAGES];  end
         2'd2: begin c_raw = -x_ff[STAGES]; s_raw = -y_ff[STAGES]; end
         default: begin c_raw = y_ff[STAGES]; s_raw = -x_ff[STAGES]; end
      endcase
   end

   // round to Q15
   assign c_sum = (CW+1)'(c_raw) + (CW+1)'(16384);
   assign s_sum = (CW+1)'(s_raw) + (CW+1)'(16384);

   always_ff @(posedge clock) begin
      if (adv) begin
         cos_ff <= c_sum[32:15];
         sin_ff <= s_sum[32:15];
      end
   end

   assign cos_out = cos_ff;
   assign sin_out = sin_ff;

endmodule

// ----- rtl/euler_zyx_to_quaternion.sv -----
// Top level: Z-Y-X Euler angles (Q8.16 rad) to a unit quaternion (Q1.15) with range and norm checks.
// Depends on ezq_pkg and ezq_cordic.
//
//   channel | direction | handshake          | payload
//   req     | in        | req_valid/req_stall | yaw_angle, pitch_angle, roll_angle
//   rsp     | out       | rsp_valid/rsp_stall | quat_w/x/y/z, status
//   csr     | in        | APB write/read      | max_angle at byte address 0
//
// One item per cycle while req_stall is low; rsp_valid is delayed by the input stages, the CORDIC
// stages and the three multiply levels (trig pairs, triple products, squares).
// Reset clears all valid bits and loads max_angle with 32 pi.
// A skid register behind the output catches the item in flight when rsp_stall rises;
// req_stall is high only while that skid register is full.
module euler_zyx_to_quaternion #(
   parameter int ANGLE_FRAC_BITS = ezq_pkg::ANGLE_FRAC_BITS,
   parameter int TRIG_STAGES     = ezq_pkg::TRIG_STAGES
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_stall,
   input  logic signed [ezq_pkg::ANGLE_W-1:0]   req_yaw_angle,
   input  logic signed [ezq_pkg::ANGLE_W-1:0]   req_pitch_angle,
   input  logic signed [ezq_pkg::ANGLE_W-1:0]   req_roll_angle,
   output logic                                 rsp_valid,
   input  logic                                 rsp_stall,
   output logic signed [ezq_pkg::QUAT_W-1:0]    rsp_quat_w,
   output logic signed [ezq_pkg::QUAT_W-1:0]    rsp_quat_x,
   output logic signed [ezq_pkg::QUAT_W-1:0]    rsp_quat_y,
   output logic signed [ezq_pkg::QUAT_W-1:0]    rsp_quat_z,
   output logic        [ezq_pkg::STATUS_W-1:0]  rsp_status,
   input  logic                                 psel,
   input  logic                                 penable,
   input  logic                                 pwrite,
   input  logic        [2:0]                    paddr,
   input  logic        [31:0]                   pwdata,
   output logic        [31:0]                   prdata,
   output logic                                 pready
);

   localparam int AW   = ezq_pkg::ANGLE_W;
   localparam int PW   = AW + 31;
   localparam int CL   = TRIG_STAGES + 2;
   localparam int TW   = ezq_pkg::TW;
   localparam int QW   = ezq_pkg::QUAT_W;
   localparam int NP   = 5;   // product/norm stages behind the CORDIC

   // ---------------- configuration ----------------
   logic [ezq_pkg::MAX_W-1:0] max_angle_ff;

   assign pready = 1'b1;
   assign prdata = (paddr[2] == ezq_pkg::REG_MAX_ANGLE) ? 32'(max_angle_ff) : '0;

   always_ff @(posedge clock) begin
      if (reset) begin
         max_angle_ff <= ezq_pkg::MAX_ANGLE_RST;
      end else if (psel && penable && pwrite && paddr[2] == ezq_pkg::REG_MAX_ANGLE) begin
         max_angle_ff <= pwdata[ezq_pkg::MAX_W-1:0];
      end
   end

   // ---------------- flow control ----------------
   logic adv;
   logic skid_valid_ff;
   assign adv       = !skid_valid_ff;
   assign req_stall = skid_valid_ff;

   // ---------------- stage 1: input register ----------------
   logic                 v1_ff;
   logic signed [AW-1:0] ang1_ff [0:2];

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
      end else if (adv) begin
         v1_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         ang1_ff[0] <= req_yaw_angle;
         ang1_ff[1] <= req_pitch_angle;
         ang1_ff[2] <= req_roll_angle;
      end
   end

   // ---------------- stage 2: range check, turn phase ----------------
   logic                 v2_ff, bad2_ff;
   logic signed [PW-1:0] prod2_ff [0:2];
   logic [2:0]           over;
   logic signed [PW-1:0] prod_c [0:2];

   for (genvar k = 0; k < 3; k++) begin : g_phase
      logic signed [AW:0] mag;
      assign mag       = ang1_ff[k][AW-1] ? -(AW+1)'(ang1_ff[k]) : (AW+1)'(ang1_ff[k]);
      assign over[k]   = mag > $signed((AW+1)'(max_angle_ff));
      assign prod_c[k] = PW'(ang1_ff[k]) * $signed(PW'(ezq_pkg::INV_TWO_PI));
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v2_ff <= 1'b0;
      end else if (adv) begin
         v2_ff <= v1_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         bad2_ff <= |over;
         for (int k = 0; k < 3; k++) prod2_ff[k] <= prod_c[k];
      end
   end

   // ---------------- stage 3: quadrant and residual ----------------
   logic                         v3_ff, bad3_ff;
   logic signed [ezq_pkg::CW-1:0] z3_ff [0:2];
   logic [1:0]                    quad3_ff [0:2];
   logic [1:0]                    quad_c [0:2];
   logic [31:0]                   resid_c [0:2];

   for (genvar k = 0; k < 3; k++) begin : g_quad
      logic [31:0] phase, biased;
      assign phase      = prod2_ff[k][ANGLE_FRAC_BITS+32:ANGLE_FRAC_BITS+1];
      assign biased     = phase + 32'h2000_0000;
      assign quad_c[k]  = biased[31:30];
      assign resid_c[k] = phase - {quad_c[k], 30'd0};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v3_ff <= 1'b0;
      end else if (adv) begin
         v3_ff <= v2_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         bad3_ff <= bad2_ff;
         for (int k = 0; k < 3; k++) begin
            z3_ff[k]    <= ezq_pkg::CW'($signed(resid_c[k]));
            quad3_ff[k] <= quad_c[k];
         end
      end
   end

   // ---------------- CORDIC lanes: 0 yaw, 1 pitch, 2 roll ----------------
   ezq_pkg::trig_type cosv [0:2];
   ezq_pkg::trig_type sinv [0:2];

   for (genvar k = 0; k < 3; k++) begin : g_lane
      ezq_cordic #(.STAGES(TRIG_STAGES)) u_cordic (
         .clock   (clock),
         .adv     (adv),
         .z_in    (z3_ff[k]),
         .quad_in (quad3_ff[k]),
         .cos_out (cosv[k]),
         .sin_out (sinv[k])
      );
   end

   logic cv_ff [0:CL-1];
   logic cb_ff [0:CL-1];

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < CL; i++) cv_ff[i] <= 1'b0;
      end else if (adv) begin
         cv_ff[0] <= v3_ff;
         for (int i = 1; i < CL; i++) cv_ff[i] <= cv_ff[i-1];
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         cb_ff[0] <= bad3_ff;
         for (int i = 1; i < CL; i++) cb_ff[i] <= cb_ff[i-1];
      end
   end

   // ---------------- product and norm stages ----------------
   logic pv_ff [0:NP-1];
   logic pb_ff [0:NP-1];

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < NP; i++) pv_ff[i] <= 1'b0;
      end else if (adv) begin
         pv_ff[0] <= cv_ff[CL-1];
         for (int i = 1; i < NP; i++) pv_ff[i] <= pv_ff[i-1];
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         pb_ff[0] <= cb_ff[CL-1];
         for (int i = 1; i < NP; i++) pb_ff[i] <= pb_ff[i-1];
      end
   end

   // P1: roll x pitch pairs, keep yaw terms alongside
   logic signed [2*TW-1:0] crcp_ff, srsp_ff, crsp_ff, srcp_ff;
   ezq_pkg::trig_type      cy_ff, sy_ff;

   always_ff @(posedge clock) begin
      if (adv) begin
         crcp_ff <= (2*TW)'(cosv[2]) * (2*TW)'(cosv[1]);
         srsp_ff <= (2*TW)'(sinv[2]) * (2*TW)'(sinv[1]);
         crsp_ff <= (2*TW)'(cosv[2]) * (2*TW)'(sinv[1]);
         srcp_ff <= (2*TW)'(sinv[2]) * (2*TW)'(cosv[1]);
         cy_ff   <= cosv[0];
         sy_ff   <= sinv[0];
      end
   end

   // P2: triple products, Q45
   localparam int TPW = 3*TW;
   logic signed [TPW-1:0] t_ff [0:7];

   always_ff @(posedge clock) begin
      if (adv) begin
         t_ff[0] <= TPW'(crcp_ff) * TPW'(cy_ff);
         t_ff[1] <= TPW'(srsp_ff) * TPW'(sy_ff);
         t_ff[2] <= TPW'(srcp_ff) * TPW'(cy_ff);
         t_ff[3] <= TPW'(crsp_ff) * TPW'(sy_ff);
         t_ff[4] <= TPW'(crsp_ff) * TPW'(cy_ff);
         t_ff[5] <= TPW'(srcp_ff) * TPW'(sy_ff);
         t_ff[6] <= TPW'(crcp_ff) * TPW'(sy_ff);
         t_ff[7] <= TPW'(srsp_ff) * TPW'(cy_ff);
      end
   end

   // P3: component sums
   localparam int SW = TPW + 1;
   logic signed [SW-1:0] sum_ff [0:3];

   always_ff @(posedge clock) begin
      if (adv) begin
         sum_ff[0] <= SW'(t_ff[0]) + SW'(t_ff[1]);
         sum_ff[1] <= SW'(t_ff[2]) - SW'(t_ff[3]);
         sum_ff[2] <= SW'(t_ff[4]) + SW'(t_ff[5]);
         sum_ff[3] <= SW'(t_ff[6]) - SW'(t_ff[7]);
      end
   end

   // P4: round to Q15 and saturate
   logic signed [QW-1:0] q_ff [0:3];
   logic signed [QW-1:0] q_c  [0:3];

   for (genvar k = 0; k < 4; k++) begin : g_fin
      logic signed [SW:0]    rs;
      logic signed [SW-30:0] r;
      assign rs = (SW+1)'(sum_ff[k]) + (SW+1)'(536870912);
      assign r  = rs[SW:30];
      always_comb begin
         priority if (r > (SW-29)'(32767))       q_c[k] = 16'sh7FFF;
         else if (r < -(SW-29)'(32768))          q_c[k] = 16'sh8000;
         else                                     q_c[k] = r[QW-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         for (int k = 0; k < 4; k++) q_ff[k] <= q_c[k];
      end
   end

   // P5: squares
   logic        [2*QW-1:0] sq_ff [0:3];
   logic signed [QW-1:0]   q5_ff [0:3];

   always_ff @(posedge clock) begin
      if (adv) begin
         for (int k = 0; k < 4; k++) begin
            sq_ff[k] <= (2*QW)'(32'(q_ff[k]) * 32'(q_ff[k]));
            q5_ff[k] <= q_ff[k];
         end
      end
   end

   // norm check feeds the output register
   logic        [33:0] norm_c;
   logic signed [34:0] dev_c;
   logic        [34:0] absdev_c;
   logic               norm_bad_c;
   logic [ezq_pkg::STATUS_W-1:0] status_c;
   logic                         zero_c;

   assign norm_c     = 34'(sq_ff[0]) + 34'(sq_ff[1]) + 34'(sq_ff[2]) + 34'(sq_ff[3]);
   assign dev_c      = $signed(35'(norm_c)) - $signed(35'(ezq_pkg::NORM_ONE));
   assign absdev_c   = dev_c[34] ? 35'(-dev_c) : 35'(dev_c);
   assign norm_bad_c = absdev_c > 35'(ezq_pkg::NORM_TOL);

   always_comb begin
      priority if (pb_ff[NP-1]) status_c = ezq_pkg::ST_RANGE;
      else if (norm_bad_c)      status_c = ezq_pkg::ST_NORM_FAIL;
      else                      status_c = ezq_pkg::ST_OK;
   end
   assign zero_c = (status_c != ezq_pkg::ST_OK);

   // ---------------- output register and skid ----------------
   logic                 rsp_valid_ff;
   logic signed [QW-1:0] rsp_q_ff [0:3];
   logic [ezq_pkg::STATUS_W-1:0] rsp_status_ff;
   logic signed [QW-1:0] skid_q_ff [0:3];
   logic [ezq_pkg::STATUS_W-1:0] skid_status_ff;
   logic                 out_free;
   logic                 last_valid;

   assign out_free   = !rsp_valid_ff || !rsp_stall;
   assign last_valid = pv_ff[NP-1];

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else if (adv) begin
         if (out_free) begin
            rsp_valid_ff <= last_valid;
         end else if (last_valid) begin
            skid_valid_ff <= 1'b1;
         end
      end else if (out_free) begin
         rsp_valid_ff  <= 1'b1;
         skid_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         if (out_free) begin
            rsp_status_ff <= status_c;
            for (int k = 0; k < 4; k++) rsp_q_ff[k] <= zero_c ? '0 : q5_ff[k];
         end else begin
            skid_status_ff <= status_c;
            for (int k = 0; k < 4; k++) skid_q_ff[k] <= zero_c ? '0 : q5_ff[k];
         end
      end else if (out_free) begin
         rsp_status_ff <= skid_status_ff;
         for (int k = 0; k < 4; k++) rsp_q_ff[k] <= skid_q_ff[k];
      end
   end

   assign rsp_valid  = rsp_valid_ff;
   assign rsp_quat_w = rsp_q_ff[0];
   assign rsp_quat_x = rsp_q_ff[1];
   assign rsp_quat_y = rsp_q_ff[2];
   assign rsp_quat_z = rsp_q_ff[3];
   assign rsp_status = rsp_status_ff;

   // ---------------- assertions ----------------
   a_fail_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_status_ff != ezq_pkg::ST_OK) |->
      (rsp_q_ff[0] == '0 && rsp_q_ff[1] == '0 && rsp_q_ff[2] == '0 && rsp_q_ff[3] == '0))
      else $error("failed item carries a nonzero quaternion");

   a_skid_behind_out: assert property (@(posedge clock) disable iff (reset)
      skid_valid_ff |-> rsp_valid_ff)
      else $error("skid holds an item while the output register is empty");

   a_skid_holds: assert property (@(posedge clock) disable iff (reset)
      (skid_valid_ff && rsp_stall) |=> skid_valid_ff)
      else $error("skid item dropped while the output was stalled");

endmodule

// ----- tb/sv/tb_top.sv -----
// Self-checking testbench for euler_zyx_to_quaternion: a bit-exact predictor of the
// CORDIC half-angle trig, quaternion product, range check and norm check. Depends on ezq_pkg.
`timescale 1ns / 1ps
module tb_top;

   typedef struct packed {
      logic signed [ezq_pkg::QUAT_W-1:0]   w, x, y, z;
      logic        [ezq_pkg::STATUS_W-1:0] status;
   } quat_type;

   localparam int WATCHDOG_LIMIT = 5000;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_stall;
   logic signed [ezq_pkg::ANGLE_W-1:0] req_yaw_angle = '0, req_pitch_angle = '0,
                                       req_roll_angle = '0;
   logic rsp_valid;
   logic rsp_stall = 1'b0;
   logic signed [ezq_pkg::QUAT_W-1:0] rsp_quat_w, rsp_quat_x, rsp_quat_y, rsp_quat_z;
   logic [ezq_pkg::STATUS_W-1:0] rsp_status;
   logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
   logic [2:0] paddr = '0;
   logic [31:0] pwdata = '0;
   logic [31:0] prdata;
   logic pready;

   euler_zyx_to_quaternion dut (.*);

   quat_type expected_quats[$];
   logic [ezq_pkg::MAX_W-1:0] angle_limit = ezq_pkg::MAX_ANGLE_RST;
   int errors = 0;
   bit req_gaps = 1'b0;
   bit rsp_gaps = 1'b0;
   int hold_left = 0;
   int idle_cycles = 0;
   bit req_seen, rsp_seen;

   longint atan_tab[24] = '{536870912, 316933406, 167458907, 85004756, 42667331, 21354465,
      10679838, 5340245, 2670163, 1335087, 667544, 333772, 166886, 83443, 41722, 20861,
      10430, 5215, 2608, 1304, 652, 326, 163, 81};

   initial forever #2 clock = ~clock;

   // sine and cosine of half the angle, Q15
   function automatic void half_sincos(input logic signed [ezq_pkg::ANGLE_W-1:0] a,
                                       output longint c, output longint s);
      logic [63:0] prod;
      logic [31:0] phase, biased, d;
      logic [1:0] quad;
      longint x, y, z, nx;
      prod = $unsigned(longint'(a)) * 64'd683565276;
      phase = prod[48:17];
      biased = phase + 32'h2000_0000;
      quad = biased[31:30];
      d = phase - {quad, 30'b0};
      z = longint'($signed(d));
      x = 652032875;
      y = 0;
      for (int i = 0; i < ezq_pkg::TRIG_STAGES && i < 24; i++) begin
         if (z >= 0) begin
            nx = x - (y >>> i);
            y = y + (x >>> i);
            z = z - atan_tab[i];
         end else begin
            nx = x + (y >>> i);
            y = y - (x >>> i);
            z = z + atan_tab[i];
         end
         x = nx;
      end
      case (quad)
         2'd0: begin c = x; s = y; end
         2'd1: begin c = -y; s = x; end
         2'd2: begin c = -x; s = -y; end
         default: begin c = y; s = -x; end
      endcase
      c = (c + 16384) >>> 15;
      s = (s + 16384) >>> 15;
   endfunction

   function automatic longint round_sat(input longint v);
      longint r;
      r = (v + 536870912) >>> 30;
      if (r > 32767) r = 32767;
      if (r < -32768) r = -32768;
      return r;
   endfunction

   function automatic quat_type predict_quat(input logic signed [ezq_pkg::ANGLE_W-1:0] yaw,
                                             pit, rol);
      quat_type q;
      longint cy, sy, cp, sp, cr, sr, qw, qx, qy, qz, n, dev;
      q = '{0, 0, 0, 0, ezq_pkg::ST_OK};
      if ((yaw < 0 ? -longint'(yaw) : longint'(yaw)) > longint'(angle_limit) ||
          (pit < 0 ? -longint'(pit) : longint'(pit)) > longint'(angle_limit) ||
          (rol < 0 ? -longint'(rol) : longint'(rol)) > longint'(angle_limit)) begin
         q.status = ezq_pkg::ST_RANGE;
         return q;
      end
      half_sincos(yaw, cy, sy);
      half_sincos(pit, cp, sp);
      half_sincos(rol, cr, sr);
      qw = round_sat(cr * cp * cy + sr * sp * sy);
      qx = round_sat(sr * cp * cy - cr * sp * sy);
      qy = round_sat(cr * sp * cy + sr * cp * sy);
      qz = round_sat(cr * cp * sy - sr * sp * cy);
      n = qw * qw + qx * qx + qy * qy + qz * qz - 1073741824;
      dev = n < 0 ? -n : n;
      if (dev > 10737418) begin
         q.status = ezq_pkg::ST_NORM_FAIL;
         return q;
      end
      q.w = qw[15:0];
      q.x = qx[15:0];
      q.y = qy[15:0];
      q.z = qz[15:0];
      return q;
   endfunction

   // Stall changes only after a rising edge, so the value at the falling edge decides the next one.
   task automatic send_angles(input logic signed [ezq_pkg::ANGLE_W-1:0] yaw, pit, rol);
      bit taken;
      if (req_gaps && $urandom_range(0, 3) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 17)) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_yaw_angle <= yaw;
      req_pitch_angle <= pit;
      req_roll_angle <= rol;
      do begin
         @(negedge clock);
         taken = !req_stall;
         @(posedge clock);
      end while (!taken);
      expected_quats.push_back(predict_quat(yaw, pit, rol));
   endtask

   task automatic drain();
      req_valid <= 1'b0;
      wait (expected_quats.size() == 0);
      repeat (ezq_pkg::TRIG_STAGES + 20) @(posedge clock);
   endtask

   task automatic write_max_angle(input logic [31:0] value);
      @(posedge clock);
      psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
      paddr <= {ezq_pkg::REG_MAX_ANGLE, 2'b00}; pwdata <= value;
      @(posedge clock);
      penable <= 1'b1;
      @(posedge clock);
      psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
      angle_limit = value[ezq_pkg::MAX_W-1:0];
   endtask

   function automatic logic signed [ezq_pkg::ANGLE_W-1:0] rand_in_limit();
      return ezq_pkg::ANGLE_W'(int'($urandom_range(0, 2 * angle_limit)) - int'(angle_limit));
   endfunction

   function automatic logic signed [ezq_pkg::ANGLE_W-1:0] rand_angle();
      if ($urandom_range(0, 4) == 0) return ezq_pkg::ANGLE_W'($urandom);
      return rand_in_limit();
   endfunction

   task automatic test_directed();
      send_angles(0, 0, 0);
      send_angles(24'sd6588397, 0, 0);
      send_angles(-24'sd6588397, 24'sd6588397, -24'sd6588397);
      send_angles(24'sd6588398, 0, 0);
      send_angles(0, -24'sd6588398, 0);
      send_angles(0, 0, 24'sd8388607);
      send_angles(-24'sd8388608, 0, 0);
      send_angles(0, -24'sd8388608, 0);
      send_angles(24'sd205887, 0, 0);
      send_angles(0, 24'sd102944, 0);
      send_angles(0, 0, -24'sd102944);
      send_angles(24'sd411775, 24'sd411775, 24'sd411775);
      send_angles(24'sd1, -24'sd1, 24'sd1);
      send_angles(24'sd308831, -24'sd308831, 24'sd51472);
      send_angles(24'sd3294199, 24'sd1647099, -24'sd823550);
      drain();
   endtask

   task automatic test_limits();
      write_max_angle(32'd0);
      send_angles(0, 0, 0);
      send_angles(1, 0, 0);
      send_angles(0, 0, -1);
      drain();
      write_max_angle(32'hFFFF_FFFF);
      send_angles(24'sd8388607, -24'sd8388607, 24'sd8388607);
      send_angles(-24'sd8388608, 0, 0);
      for (int i = 0; i < 40; i++) send_angles(ezq_pkg::ANGLE_W'($urandom),
                                               ezq_pkg::ANGLE_W'($urandom),
                                               ezq_pkg::ANGLE_W'($urandom));
      drain();
   endtask

   task automatic test_random();
      req_gaps = 1'b1;
      rsp_gaps = 1'b1;
      for (int i = 0; i < 300; i++) begin
         if (i % 100 == 0) begin
            drain();
            write_max_angle(i == 0 ? 32'd6588397 : $urandom_range(1, 8388607));
         end
         send_angles(rand_angle(), rand_angle(), rand_angle());
      end
      drain();
   endtask

   task automatic test_backpressure();
      req_gaps = 1'b0;
      hold_left = 300;
      for (int i = 0; i < 60; i++) send_angles(rand_angle(), rand_angle(), rand_angle());
      drain();
   endtask

   task automatic test_full_rate();
      rsp_gaps = 1'b0;
      write_max_angle(32'd6588397);
      for (int i = 0; i < 50; i++) send_angles(rand_angle(), rand_angle(), rand_angle());
      drain();
   endtask

   // receiver: long hold-off when asked, else random stall bursts
   initial begin
      forever begin
         if (hold_left > 0) begin
            rsp_stall <= 1'b1;
            hold_left--;
            @(posedge clock);
         end else if (rsp_gaps && $urandom_range(0, 3) == 0) begin
            rsp_stall <= 1'b1;
            repeat ($urandom_range(1, 17)) @(posedge clock);
         end else begin
            rsp_stall <= 1'b0;
            @(posedge clock);
         end
      end
   end

   // check each accepted result against the oldest prediction
   initial begin
      quat_type got, want;
      forever begin
         @(negedge clock);
         req_seen = req_valid && !req_stall;
         rsp_seen = rsp_valid && !rsp_stall;
         got = '{rsp_quat_w, rsp_quat_x, rsp_quat_y, rsp_quat_z, rsp_status};
         @(posedge clock);
         if (req_seen || rsp_seen) idle_cycles = 0;
         else idle_cycles++;
         if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("%0t timeout", $realtime);
            $display("tb_top failed");
            $finish;
         end
         if (rsp_seen) begin
            if (expected_quats.size() == 0) begin
               errors++;
               $display("%0t unexpected result w=%0d x=%0d y=%0d z=%0d status=%0d",
                        $realtime, got.w, got.x, got.y, got.z, got.status);
            end else begin
               want = expected_quats.pop_front();
               if (got != want) begin
                  errors++;
                  $display("%0t mismatch: expected w=%0d x=%0d y=%0d z=%0d status=%0d",
                           $realtime, want.w, want.x, want.y, want.z, want.status);
                  $display("%0t           actual   w=%0d x=%0d y=%0d z=%0d status=%0d",
                           $realtime, got.w, got.x, got.y, got.z, got.status);
               end
            end
         end
      end
   end

   initial begin
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed();
      test_limits();
      test_random();
      test_backpressure();
      test_full_rate();
      if (expected_quats.size() != 0) begin
         errors++;
         $display("%0t %0d results never arrived", $realtime, expected_quats.size());
      end
      if (errors == 0) $display("tb_top passed");
      else $display("tb_top failed");
      $finish;
   end

endmodule
